// File: hw/rtl/blpwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpwm_pkg: shared constants and types for the breathing LED block
// Periods, field widths, reciprocal constants and pipeline control types.
// ----------------------------------------------------------------------------
package blpwm_pkg;

    localparam int STEP_W = 16;
    localparam int DEB_W  = 16;
    localparam int PWM_W  = 11;
    localparam int FADE_W = 22;
    localparam int FOLD_W = 21;
    localparam int DUTY_W = 11;

    localparam int PWM_PERIOD    = 2000;
    localparam int BREATH_PERIOD = 4000000;
    localparam int BREATH_HALF   = BREATH_PERIOD / 2;

    // step / PWM_PERIOD by reciprocal, exact for every 16-bit step
    localparam int STEP_RECIP = 67109;
    localparam int STEP_SHIFT = 27;
    localparam int Q_W        = 6;
    localparam int QPROD_W    = STEP_SHIFT + Q_W;

    // fade * PWM_PERIOD / BREATH_HALF == fade / 1000, exact for fade <= BREATH_HALF
    localparam int DUTY_RECIP   = 2147484;
    localparam int DUTY_SHIFT   = 31;
    localparam int DRECIP_W     = 22;
    localparam int DPROD_W      = FOLD_W + DRECIP_W;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd20000;

    localparam int NUM_KEYS   = 3;
    localparam int KEY_FASTER = 0;
    localparam int KEY_SLOWER = 1;
    localparam int KEY_STOP   = 2;

    typedef logic [STEP_W-1:0]   t_step;
    typedef logic [DEB_W-1:0]    t_deb;
    typedef logic [PWM_W-1:0]    t_pwm;
    typedef logic [FADE_W-1:0]   t_fade;
    typedef logic [DUTY_W-1:0]   t_duty;
    typedef logic [NUM_KEYS-1:0] t_keys;

    // load strobes, one per pipeline stage
    typedef struct packed {
        logic a;
        logic b;
        logic c;
        logic d;
        logic e;
        logic f;
    } t_pipe_en;

endpackage

// File: hw/rtl/blpwm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpwm_if: input and result channels of the breathing LED block
// Valid/ready channels; a beat moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface blpwm_in_if;
    logic                valid;
    logic                ready;
    blpwm_pkg::t_step    step_us;
    logic                faster_key_down;
    logic                slower_key_down;
    logic                stop_key_down;

    modport source (
        output valid, step_us, faster_key_down, slower_key_down, stop_key_down,
        input  ready
    );
    modport sink (
        input  valid, step_us, faster_key_down, slower_key_down, stop_key_down,
        output ready
    );
endinterface

interface blpwm_out_if;
    logic                valid;
    logic                ready;
    logic                led_on;
    logic                is_running;
    blpwm_pkg::t_duty    duty_now;

    modport source (
        output valid, led_on, is_running, duty_now,
        input  ready
    );
    modport sink (
        input  valid, led_on, is_running, duty_now,
        output ready
    );
endinterface

// File: hw/rtl/blpwm_step_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpwm_step_mod: step reduction modulo the PWM period
// Two stages: reciprocal multiply for the quotient, then the remainder.
// ----------------------------------------------------------------------------
module blpwm_step_mod (
    input  logic                i_clk,
    input  blpwm_pkg::t_pipe_en i_en,
    input  blpwm_pkg::t_step    i_step,
    input  blpwm_pkg::t_keys    i_keys,
    output blpwm_pkg::t_step    o_step,
    output blpwm_pkg::t_keys    o_keys,
    output blpwm_pkg::t_pwm     o_rem
);

    logic [blpwm_pkg::QPROD_W-1:0] w_qprod;
    logic [blpwm_pkg::STEP_W-1:0]  w_qd;

    blpwm_pkg::t_step              r_a_step;
    blpwm_pkg::t_keys              r_a_keys;
    logic [blpwm_pkg::Q_W-1:0]     r_a_q;
    blpwm_pkg::t_step              r_b_step;
    blpwm_pkg::t_keys              r_b_keys;
    blpwm_pkg::t_pwm               r_b_rem;

    assign w_qprod = blpwm_pkg::QPROD_W'(i_step)
                   * blpwm_pkg::QPROD_W'(blpwm_pkg::STEP_RECIP);
    assign w_qd    = blpwm_pkg::STEP_W'(r_a_q)
                   * blpwm_pkg::STEP_W'(blpwm_pkg::PWM_PERIOD);

    always_ff @(posedge i_clk) begin
        if (i_en.a) begin
            r_a_step <= i_step;
            r_a_keys <= i_keys;
            r_a_q    <= w_qprod[blpwm_pkg::QPROD_W-1:blpwm_pkg::STEP_SHIFT];
        end
        if (i_en.b) begin
            r_b_step <= r_a_step;
            r_b_keys <= r_a_keys;
            r_b_rem  <= blpwm_pkg::PWM_W'(r_a_step - w_qd);
        end
    end

    assign o_step = r_b_step;
    assign o_keys = r_b_keys;
    assign o_rem  = r_b_rem;

endmodule

// File: hw/rtl/blpwm_key_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpwm_key_lane: debounce for one key
// Saturating hold timer; reports the settled level and a press event.
// ----------------------------------------------------------------------------
module blpwm_key_lane (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_level,
    input  blpwm_pkg::t_step  i_step,
    input  blpwm_pkg::t_deb   i_limit,
    output logic              o_settled,
    output logic              o_press
);

    logic                      r_candidate;
    logic                      r_settled;
    blpwm_pkg::t_deb           r_timer;
    logic                      n_candidate;
    logic                      n_settled;
    blpwm_pkg::t_deb           n_timer;
    logic [blpwm_pkg::DEB_W:0] w_sum;

    always_comb begin
        w_sum       = {1'b0, r_timer} + (blpwm_pkg::DEB_W + 1)'(i_step);
        n_candidate = r_candidate;
        n_settled   = r_settled;
        n_timer     = r_timer;
        o_press     = 1'b0;
        if (i_level != r_candidate) begin
            // level moved: restart the hold time
            n_candidate = i_level;
            n_timer     = '0;
        end else begin
            n_timer = (w_sum >= {1'b0, i_limit}) ? i_limit : w_sum[blpwm_pkg::DEB_W-1:0];
            if (n_timer == i_limit && r_settled != i_level) begin
                n_settled = i_level;
                o_press   = i_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_candidate <= 1'b0;
            r_settled   <= 1'b0;
            r_timer     <= '0;
        end else if (i_en) begin
            r_candidate <= n_candidate;
            r_settled   <= n_settled;
            r_timer     <= n_timer;
        end
    end

    assign o_settled = n_settled;

endmodule

// File: hw/rtl/blpwm_duty.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpwm_duty: triangle fade to duty threshold and LED compare
// Fold stage, reciprocal multiply stage, registered result stage.
// ----------------------------------------------------------------------------
module blpwm_duty (
    input  logic                i_clk,
    input  blpwm_pkg::t_pipe_en i_en,
    input  logic                i_run,
    input  blpwm_pkg::t_pwm     i_pwm,
    input  blpwm_pkg::t_fade    i_fade,
    output logic                o_led,
    output logic                o_run,
    output blpwm_pkg::t_duty    o_duty
);

    logic [blpwm_pkg::FOLD_W-1:0]  w_fold;
    logic [blpwm_pkg::DPROD_W-1:0] w_prod;

    logic                          r_d_run;
    blpwm_pkg::t_pwm               r_d_pwm;
    logic [blpwm_pkg::FOLD_W-1:0]  r_d_fold;
    logic                          r_e_run;
    blpwm_pkg::t_pwm               r_e_pwm;
    blpwm_pkg::t_duty              r_e_duty;
    logic                          r_f_led;
    logic                          r_f_run;
    blpwm_pkg::t_duty              r_f_duty;

    // falling half of the breath mirrors the rising half
    assign w_fold = (i_fade < blpwm_pkg::FADE_W'(blpwm_pkg::BREATH_HALF))
                  ? blpwm_pkg::FOLD_W'(i_fade)
                  : blpwm_pkg::FOLD_W'(blpwm_pkg::FADE_W'(blpwm_pkg::BREATH_PERIOD) - i_fade);

    assign w_prod = blpwm_pkg::DPROD_W'(r_d_fold)
                  * blpwm_pkg::DPROD_W'(blpwm_pkg::DUTY_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en.d) begin
            r_d_run  <= i_run;
            r_d_pwm  <= i_pwm;
            r_d_fold <= w_fold;
        end
        if (i_en.e) begin
            r_e_run  <= r_d_run;
            r_e_pwm  <= r_d_pwm;
            r_e_duty <= w_prod[blpwm_pkg::DUTY_SHIFT+blpwm_pkg::DUTY_W-1:blpwm_pkg::DUTY_SHIFT];
        end
        if (i_en.f) begin
            r_f_run  <= r_e_run;
            r_f_led  <= r_e_run && (r_e_pwm < r_e_duty);
            r_f_duty <= r_e_run ? r_e_duty : '0;
        end
    end

    assign o_led  = r_f_led;
    assign o_run  = r_f_run;
    assign o_duty = r_f_duty;

endmodule

// File: hw/rtl/breathing_led_pwm_with_debounced_keys.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// breathing_led_pwm_with_debounced_keys: breathing LED with three debounced keys
// Three debounce lanes, a merge stage for run state and phases, duty pipeline.
// ----------------------------------------------------------------------------
// Each accepted input beat passes stages A to F in order and leaves as its result beat.
// Throughput: one beat per cycle while the output is not stalled; each of the six stages
//   holds one item and the phase/run update at the merge stage is combinational, registered in stage C.
// Reset (synchronous, active low): pipeline empty, keys released, running,
//   both phases zero, debounce time 20000 us.
// ----------------------------------------------------------------------------
module breathing_led_pwm_with_debounced_keys (
    input  logic             i_clk,
    input  logic             i_rst_n,
    blpwm_in_if.sink         i_in,
    blpwm_out_if.source      o_out,
    input  logic             i_cfg_we,
    input  blpwm_pkg::t_deb  i_cfg_data
);

    blpwm_pkg::t_deb     r_debounce_us;
    logic                r_v_a, r_v_b, r_v_c, r_v_d, r_v_e, r_v_f;
    logic                w_rdy_a, w_rdy_b, w_rdy_c, w_rdy_d, w_rdy_e, w_rdy_f;
    blpwm_pkg::t_pipe_en w_en;

    blpwm_pkg::t_keys    w_in_keys;
    blpwm_pkg::t_step    w_b_step;
    blpwm_pkg::t_keys    w_b_keys;
    blpwm_pkg::t_pwm     w_b_rem;
    blpwm_pkg::t_keys    w_settled;
    blpwm_pkg::t_keys    w_press;

    logic                r_run;
    blpwm_pkg::t_pwm     r_pwm_phase;
    blpwm_pkg::t_fade    r_fade_phase;
    logic                n_run;
    blpwm_pkg::t_pwm     n_pwm_phase;
    blpwm_pkg::t_fade    n_fade_phase;
    logic [blpwm_pkg::PWM_W:0]  w_pwm_sum;
    logic [blpwm_pkg::FADE_W:0] w_fade_sum;

    // ---- config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_us <= blpwm_pkg::DEBOUNCE_RESET;
        end else if (i_cfg_we) begin
            r_debounce_us <= i_cfg_data;
        end
    end

    // ---- pipeline flow control: a stage loads when it is empty or drains
    assign w_rdy_f = !r_v_f || o_out.ready;
    assign w_rdy_e = !r_v_e || w_rdy_f;
    assign w_rdy_d = !r_v_d || w_rdy_e;
    assign w_rdy_c = !r_v_c || w_rdy_d;
    assign w_rdy_b = !r_v_b || w_rdy_c;
    assign w_rdy_a = !r_v_a || w_rdy_b;

    assign w_en.a = w_rdy_a && i_in.valid;
    assign w_en.b = w_rdy_b && r_v_a;
    assign w_en.c = w_rdy_c && r_v_b;
    assign w_en.d = w_rdy_d && r_v_c;
    assign w_en.e = w_rdy_e && r_v_d;
    assign w_en.f = w_rdy_f && r_v_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
            r_v_b <= 1'b0;
            r_v_c <= 1'b0;
            r_v_d <= 1'b0;
            r_v_e <= 1'b0;
            r_v_f <= 1'b0;
        end else begin
            if (w_rdy_a) r_v_a <= i_in.valid;
            if (w_rdy_b) r_v_b <= r_v_a;
            if (w_rdy_c) r_v_c <= r_v_b;
            if (w_rdy_d) r_v_d <= r_v_c;
            if (w_rdy_e) r_v_e <= r_v_d;
            if (w_rdy_f) r_v_f <= r_v_e;
        end
    end

    assign i_in.ready = w_rdy_a;

    // ---- step prescale
    assign w_in_keys[blpwm_pkg::KEY_FASTER] = i_in.faster_key_down;
    assign w_in_keys[blpwm_pkg::KEY_SLOWER] = i_in.slower_key_down;
    assign w_in_keys[blpwm_pkg::KEY_STOP]   = i_in.stop_key_down;

    blpwm_step_mod u_step_mod (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_step (i_in.step_us),
        .i_keys (w_in_keys),
        .o_step (w_b_step),
        .o_keys (w_b_keys),
        .o_rem  (w_b_rem)
    );

    // ---- debounce lanes
    for (genvar k = 0; k < blpwm_pkg::NUM_KEYS; k++) begin : g_lane
        blpwm_key_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en.c),
            .i_level   (w_b_keys[k]),
            .i_step    (w_b_step),
            .i_limit   (r_debounce_us),
            .o_settled (w_settled[k]),
            .o_press   (w_press[k])
        );
    end

    // ---- merge: run state and phases; these registers are also stage C
    always_comb begin
        n_run        = r_run;
        n_pwm_phase  = r_pwm_phase;
        n_fade_phase = r_fade_phase;
        w_pwm_sum    = {1'b0, r_pwm_phase} + {1'b0, w_b_rem};
        w_fade_sum   = {1'b0, r_fade_phase} + (blpwm_pkg::FADE_W + 1)'(w_b_step);
        if (w_settled[blpwm_pkg::KEY_STOP]) begin
            n_run        = 1'b0;
            n_pwm_phase  = '0;
            n_fade_phase = '0;
        end else if (w_press[blpwm_pkg::KEY_FASTER] != w_press[blpwm_pkg::KEY_SLOWER]) begin
            n_run = 1'b1;
        end
        if (n_run) begin
            n_pwm_phase = (w_pwm_sum >= (blpwm_pkg::PWM_W + 1)'(blpwm_pkg::PWM_PERIOD))
                        ? blpwm_pkg::PWM_W'(w_pwm_sum
                              - (blpwm_pkg::PWM_W + 1)'(blpwm_pkg::PWM_PERIOD))
                        : blpwm_pkg::PWM_W'(w_pwm_sum);
            n_fade_phase = (w_fade_sum >= (blpwm_pkg::FADE_W + 1)'(blpwm_pkg::BREATH_PERIOD))
                         ? blpwm_pkg::FADE_W'(w_fade_sum
                               - (blpwm_pkg::FADE_W + 1)'(blpwm_pkg::BREATH_PERIOD))
                         : blpwm_pkg::FADE_W'(w_fade_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run        <= 1'b1;
            r_pwm_phase  <= '0;
            r_fade_phase <= '0;
        end else if (w_en.c) begin
            r_run        <= n_run;
            r_pwm_phase  <= n_pwm_phase;
            r_fade_phase <= n_fade_phase;
        end
    end

    // ---- duty and LED
    blpwm_duty u_duty (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_run  (r_run),
        .i_pwm  (r_pwm_phase),
        .i_fade (r_fade_phase),
        .o_led  (o_out.led_on),
        .o_run  (o_out.is_running),
        .o_duty (o_out.duty_now)
    );

    assign o_out.valid = r_v_f;

    // ---- checks
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pwm_phase < blpwm_pkg::PWM_W'(blpwm_pkg::PWM_PERIOD))
        && ({1'b0, r_fade_phase} < (blpwm_pkg::FADE_W + 1)'(blpwm_pkg::BREATH_PERIOD)))
        else $error("phase out of range");

    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en.c && w_settled[blpwm_pkg::KEY_STOP])
        |=> (!r_run && r_pwm_phase == '0 && r_fade_phase == '0))
        else $error("settled stop key did not stop the block");

    a_stopped_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.is_running) |-> (!o_out.led_on && o_out.duty_now == '0))
        else $error("LED or duty active while stopped");

    a_stalled_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_in.ready) |-> (r_v_a && r_v_b && r_v_c && r_v_d && r_v_e && r_v_f))
        else $error("input stalled with a free stage");

endmodule

// File: bench/tb_breathing_led_pwm_with_debounced_keys.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_breathing_led_pwm_with_debounced_keys: self-checking bench for the
// breathing LED block
// Sends timed key samples over the input channel with random gaps, takes the
// result beats with random stalls, and checks every result field against a behavioral
// model of the debounce lanes, run state and triangle fade, or a pinned row's values.
// ----------------------------------------------------------------------------
module tb_breathing_led_pwm_with_debounced_keys;

    localparam int LIMIT_CYCLES    = 400000;
    localparam int DIRECTED_ROWS   = 25;
    localparam int RAND_PHASES     = 6;
    localparam int ITEMS_PER_PHASE = 215;
    localparam int MAX_REPORTS     = 10;
    localparam int DRAIN_CYCLES    = 12;
    localparam int GAP_MAX         = 16;

    typedef struct packed {
        logic             led_on;
        logic             is_running;
        blpwm_pkg::t_duty duty_now;
    } t_led_sample;

    // one directed row; keys are {stop, slower, faster}
    typedef struct packed {
        logic             load_deb;
        blpwm_pkg::t_deb  deb_us;
        blpwm_pkg::t_step step_us;
        blpwm_pkg::t_keys keys;
        logic             pinned;
        t_led_sample      want;
    } t_key_row;

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_cfg_we;
    blpwm_pkg::t_deb i_cfg_data;

    blpwm_in_if  in_ch ();
    blpwm_out_if out_ch ();

    breathing_led_pwm_with_debounced_keys uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // behavioral state of the block
    logic             key_cand    [blpwm_pkg::NUM_KEYS];
    logic             key_stable  [blpwm_pkg::NUM_KEYS];
    blpwm_pkg::t_deb  key_hold_us [blpwm_pkg::NUM_KEYS];
    logic             running;
    blpwm_pkg::t_pwm  pwm_ph;
    blpwm_pkg::t_fade fade_ph;
    blpwm_pkg::t_deb  debounce_us;

    t_led_sample led_samples_due [$];
    t_key_row    directed_rows [DIRECTED_ROWS];

    int  cycles        = 0;
    int  beats_in      = 0;
    int  beats_out     = 0;
    int  mismatches    = 0;
    int  lit_beats     = 0;
    int  stopped_beats = 0;
    int  settings_used = 0;
    int  src_gap       = 0;
    bit  src_burst     = 1'b0;

    function automatic t_key_row dir_row(logic load_deb, blpwm_pkg::t_deb deb_us,
                                         blpwm_pkg::t_step step,
                                         blpwm_pkg::t_keys keys, logic pinned,
                                         logic led, logic run,
                                         blpwm_pkg::t_duty duty);
        t_key_row r;
        r.load_deb        = load_deb;
        r.deb_us          = deb_us;
        r.step_us         = step;
        r.keys            = keys;
        r.pinned          = pinned;
        r.want.led_on     = led;
        r.want.is_running = run;
        r.want.duty_now   = duty;
        return r;
    endfunction

    // Debounce one key; returns 1 on a settled press.
    function automatic logic settle_key(int k, logic lvl, blpwm_pkg::t_step step);
        logic [blpwm_pkg::DEB_W:0] sum;
        if (lvl != key_cand[k]) begin
            key_cand[k]    = lvl;
            key_hold_us[k] = '0;
            return 1'b0;
        end
        sum = {1'b0, key_hold_us[k]} + step;
        key_hold_us[k] = (sum >= debounce_us) ? debounce_us : sum[blpwm_pkg::DEB_W-1:0];
        if (key_hold_us[k] == debounce_us && key_stable[k] != lvl) begin
            key_stable[k] = lvl;
            return lvl;
        end
        return 1'b0;
    endfunction

    function automatic t_led_sample advance_breath(blpwm_pkg::t_step step,
                                                   blpwm_pkg::t_keys keys);
        logic        press_fast;
        logic        press_slow;
        longint      fade;
        longint      duty;
        t_led_sample r;
        press_fast = settle_key(blpwm_pkg::KEY_FASTER, keys[blpwm_pkg::KEY_FASTER], step);
        press_slow = settle_key(blpwm_pkg::KEY_SLOWER, keys[blpwm_pkg::KEY_SLOWER], step);
        void'(settle_key(blpwm_pkg::KEY_STOP, keys[blpwm_pkg::KEY_STOP], step));
        if (key_stable[blpwm_pkg::KEY_STOP]) begin
            running = 1'b0;
            pwm_ph  = '0;
            fade_ph = '0;
        end else if (press_fast != press_slow) begin
            running = 1'b1;
        end
        r = '0;
        r.is_running = running;
        if (running) begin
            pwm_ph  = blpwm_pkg::t_pwm'((longint'(pwm_ph) + longint'(step))
                                       % blpwm_pkg::PWM_PERIOD);
            fade_ph = blpwm_pkg::t_fade'((longint'(fade_ph) + longint'(step))
                                         % blpwm_pkg::BREATH_PERIOD);
            // fold the breath phase into a triangle
            fade = (longint'(fade_ph) < blpwm_pkg::BREATH_HALF)
                 ? longint'(fade_ph)
                 : blpwm_pkg::BREATH_PERIOD - longint'(fade_ph);
            duty = fade * blpwm_pkg::PWM_PERIOD / blpwm_pkg::BREATH_HALF;
            r.duty_now = blpwm_pkg::t_duty'(duty);
            r.led_on   = (longint'(pwm_ph) < duty);
        end
        return r;
    endfunction

    function automatic int draw_gap(bit burst);
        return burst ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    task automatic flag_error(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    task automatic send_keys(blpwm_pkg::t_step step, blpwm_pkg::t_keys keys,
                             logic pinned, t_led_sample want);
        t_led_sample due;
        repeat (src_gap) @(posedge i_clk);
        in_ch.valid           <= 1'b1;
        in_ch.step_us         <= step;
        in_ch.faster_key_down <= keys[blpwm_pkg::KEY_FASTER];
        in_ch.slower_key_down <= keys[blpwm_pkg::KEY_SLOWER];
        in_ch.stop_key_down   <= keys[blpwm_pkg::KEY_STOP];
        do @(posedge i_clk); while (!in_ch.ready);
        due = advance_breath(step, keys);
        if (pinned)
            due = want;
        led_samples_due.push_back(due);
        beats_in++;
        if (beats_in % 40 == 0)
            src_burst = ($urandom_range(0, 3) == 0);
        src_gap = draw_gap(src_burst);
        // hold valid only when the next beat follows at once
        if (src_gap != 0)
            in_ch.valid <= 1'b0;
    endtask

    task automatic drain_results();
        if (src_gap == 0)
            in_ch.valid <= 1'b0;
        while (led_samples_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_debounce(blpwm_pkg::t_deb value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        debounce_us = value;
        settings_used++;
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results still due",
                     cycles, led_samples_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_led_sample got;
        t_led_sample due;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.led_on     = out_ch.led_on;
            got.is_running = out_ch.is_running;
            got.duty_now   = out_ch.duty_now;
            beats_out++;
            if (led_samples_due.size() == 0) begin
                flag_error($sformatf("unexpected result led=%0b run=%0b duty=%0d",
                                     got.led_on, got.is_running, got.duty_now));
            end else begin
                due = led_samples_due.pop_front();
                if (got !== due)
                    flag_error($sformatf(
                    "result %0d: expected led=%0b run=%0b duty=%0d, got led=%0b run=%0b duty=%0d",
                    beats_out, due.led_on, due.is_running, due.duty_now,
                    got.led_on, got.is_running, got.duty_now));
                if (due.led_on)
                    lit_beats++;
                if (!due.is_running)
                    stopped_beats++;
            end
        end
    end

    initial begin : result_sink
        int stall;
        int taken;
        bit burst;
        taken = 0;
        burst = 1'b0;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (taken % 40 == 0)
                burst = ($urandom_range(0, 3) == 0);
            stall = draw_gap(burst);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            taken++;
        end
    end

    initial begin : stimulus
        blpwm_pkg::t_deb  phase_deb [RAND_PHASES];
        blpwm_pkg::t_keys held;
        blpwm_pkg::t_keys keys;
        blpwm_pkg::t_step step;
        int               pick;
        int               k;

        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_data            <= '0;
        in_ch.valid           <= 1'b0;
        in_ch.step_us         <= '0;
        in_ch.faster_key_down <= 1'b0;
        in_ch.slower_key_down <= 1'b0;
        in_ch.stop_key_down   <= 1'b0;

        for (k = 0; k < blpwm_pkg::NUM_KEYS; k++) begin
            key_cand[k]    = 1'b0;
            key_stable[k]  = 1'b0;
            key_hold_us[k] = '0;
        end
        running     = 1'b1;
        pwm_ph      = '0;
        fade_ph     = '0;
        debounce_us = blpwm_pkg::DEBOUNCE_RESET;

        directed_rows = '{
            // out of reset: running, phases at zero
            dir_row(1'b0, 16'd0,     16'd0,     3'b000, 1'b1, 1'b0, 1'b1, 11'd0),
            dir_row(1'b0, 16'd0,     16'd65535, 3'b000, 1'b1, 1'b0, 1'b1, 11'd65),
            dir_row(1'b0, 16'd0,     16'd1,     3'b000, 1'b0, 1'b0, 1'b0, 11'd0),
            // PWM phase wraps past its period
            dir_row(1'b0, 16'd0,     16'd465,   3'b000, 1'b0, 1'b0, 1'b0, 11'd0),
            // one-beat glitch on the faster key never settles
            dir_row(1'b0, 16'd0,     16'd30000, 3'b001, 1'b0, 1'b0, 1'b0, 11'd0),
            dir_row(1'b0, 16'd0,     16'd30000, 3'b000, 1'b0, 1'b0, 1'b0, 11'd0),
            dir_row(1'b0, 16'd0,     16'd0,     3'b100, 1'b0, 1'b0, 1'b0, 11'd0),
            // stop settles: LED off, duty zero
            dir_row(1'b0, 16'd0,     16'd20000, 3'b100, 1'b1, 1'b0, 1'b0, 11'd0),
            // speed press while stop is held does nothing
            dir_row(1'b0, 16'd0,     16'd0,     3'b101, 1'b1, 1'b0, 1'b0, 11'd0),
            dir_row(1'b0, 16'd0,     16'd20000, 3'b101, 1'b1, 1'b0, 1'b0, 11'd0),
            // releases settle without an event; timer saturates
            dir_row(1'b0, 16'd0,     16'd0,     3'b000, 1'b1, 1'b0, 1'b0, 11'd0),
            dir_row(1'b0, 16'd0,     16'd25000, 3'b000, 1'b1, 1'b0, 1'b0, 11'd0),
            // both speed keys at once cancel out
            dir_row(1'b0, 16'd0,     16'd0,     3'b011, 1'b1, 1'b0, 1'b0, 11'd0),
            dir_row(1'b0, 16'd0,     16'd20000, 3'b011, 1'b1, 1'b0, 1'b0, 11'd0),
            dir_row(1'b0, 16'd0,     16'd20000, 3'b000, 1'b1, 1'b0, 1'b0, 11'd0),
            dir_row(1'b0, 16'd0,     16'd20000, 3'b000, 1'b1, 1'b0, 1'b0, 11'd0),
            // a single faster press restarts from zero phases
            dir_row(1'b0, 16'd0,     16'd0,     3'b001, 1'b1, 1'b0, 1'b0, 11'd0),
            dir_row(1'b0, 16'd0,     16'd20000, 3'b001, 1'b1, 1'b1, 1'b1, 11'd20),
            dir_row(1'b0, 16'd0,     16'd5000,  3'b001, 1'b0, 1'b0, 1'b0, 11'd0),
            // longest debounce time
            dir_row(1'b1, 16'd65535, 16'd0,     3'b000, 1'b0, 1'b0, 1'b0, 11'd0),
            dir_row(1'b0, 16'd0,     16'd65535, 3'b000, 1'b0, 1'b0, 1'b0, 11'd0),
            dir_row(1'b0, 16'd0,     16'd0,     3'b100, 1'b0, 1'b0, 1'b0, 11'd0),
            dir_row(1'b0, 16'd0,     16'd30000, 3'b100, 1'b0, 1'b0, 1'b0, 11'd0),
            // debounce lowered under a running timer: clamp and settle at once
            dir_row(1'b1, 16'd10000, 16'd0,     3'b100, 1'b1, 1'b0, 1'b0, 11'd0),
            // shortest debounce time
            dir_row(1'b1, 16'd1,     16'd0,     3'b000, 1'b0, 1'b0, 1'b0, 11'd0)
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (directed_rows[r].load_deb) begin
                drain_results();
                write_debounce(directed_rows[r].deb_us);
            end
            send_keys(directed_rows[r].step_us, directed_rows[r].keys,
                      directed_rows[r].pinned, directed_rows[r].want);
        end

        phase_deb = '{16'd65535, blpwm_pkg::DEBOUNCE_RESET, 16'd500,
                      blpwm_pkg::t_deb'($urandom_range(1, 65535)), 16'd1,
                      blpwm_pkg::t_deb'($urandom_range(1, 4000))};
        held = '0;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain_results();
            write_debounce(phase_deb[ph]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // speed keys change often; stop is pressed rarely and briefly
                if ($urandom_range(0, 5) == 0)
                    held[blpwm_pkg::KEY_FASTER] = ~held[blpwm_pkg::KEY_FASTER];
                if ($urandom_range(0, 5) == 0)
                    held[blpwm_pkg::KEY_SLOWER] = ~held[blpwm_pkg::KEY_SLOWER];
                if ($urandom_range(0, held[blpwm_pkg::KEY_STOP] ? 3 : 24) == 0)
                    held[blpwm_pkg::KEY_STOP] = ~held[blpwm_pkg::KEY_STOP];
                keys = held;
                if ($urandom_range(0, 15) == 0) begin
                    k = $urandom_range(0, blpwm_pkg::NUM_KEYS - 1);
                    keys[k] = ~keys[k];
                end
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    step = blpwm_pkg::t_step'($urandom);
                else if (pick < 9)
                    step = blpwm_pkg::t_step'($urandom_range(0, 2000));
                else
                    step = ($urandom_range(0, 1) != 0) ? '1 : '0;
                send_keys(step, keys, 1'b0, '0);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (led_samples_due.size() != 0)
            flag_error($sformatf("%0d results never arrived", led_samples_due.size()));

        $display("Sent %0d key samples under %0d debounce settings; %0d results checked.",
                 beats_in, settings_used, beats_out);
        $display("Stopped on %0d results, LED lit on %0d, %0d mismatches.",
                 stopped_beats, lit_beats, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
